[rtl/bal_pkg.sv]
package bal_pkg;

  typedef enum logic [1:0] {
    MODE_SEARCH  = 2'd0,
    MODE_ACQUIRE = 2'd1,
    MODE_TRACK   = 2'd2,
    MODE_HOLD    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_UPD  = 3'd1,
    ST_DIV  = 3'd2,
    ST_CEPM = 3'd3,
    ST_CEPD = 3'd4,
    ST_OUT  = 3'd5
  } ctl_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 20;
  localparam logic [CfgIdxW-1:0] REG_CODE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_COLD    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HOLD    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COAST   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CONF    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TENT    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_UNCERT  = 3'd6;

  localparam logic [29:0] NeverLocked = 30'd1000000000;
  localparam logic [29:0] TimerMax    = 30'h3FFFFFFF;
  localparam logic [15:0] QNine       = 16'd36864;
  localparam logic [16:0] CepOne      = 17'd65536;
  localparam int unsigned DivSteps    = 34;
  // ceil(2^25 / 9): exact floor(y / 9) for y below 2^22
  localparam logic [21:0] CepRecip    = 22'd3728271;

  typedef struct packed {
    logic [15:0] quality;
    logic [15:0] elapsed;
    logic        present;
    logic        uncertain;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  lock_state;
    logic [15:0] quality_out;
    logic [16:0] cep_out;
    logic        bearing_valid;
  } out_item_t;

  typedef struct packed {
    logic load;    // capture input item
    logic update;  // run state update step
    logic div_step;
    logic cep_mul;
    logic finish;  // write result item to output
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } sts_t;

endpackage

[rtl/bal_if.sv]
interface bal_in_if;
  logic               valid;
  logic               ready;
  bal_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bal_out_if;
  logic               valid;
  logic               ready;
  bal_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bal_ctrl.sv]
module bal_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bal_pkg::sts_t sts_i,
  output bal_pkg::cmd_t cmd_o
);
  import bal_pkg::*;

  ctl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_UPD;
      ST_UPD:  state_d = sts_i.need_div ? ST_DIV : ST_CEPM;
      ST_DIV:  if (sts_i.div_done) state_d = ST_CEPM;
      ST_CEPM: state_d = ST_CEPD;
      ST_CEPD: state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_UPD:  cmd_o.update = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_CEPM: cmd_o.cep_mul = 1'b1;
      ST_CEPD: cmd_o.finish = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end
endmodule

[rtl/bal_datapath.sv]
module bal_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bal_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bal_pkg::CfgDatW-1:0]   cfg_data_i,
  input  bal_pkg::in_item_t             in_i,
  input  bal_pkg::cmd_t                 cmd_i,
  output bal_pkg::sts_t                 sts_o,
  output bal_pkg::out_item_t            out_o
);
  import bal_pkg::*;

  logic [15:0] code_q, cold_q, hold_q;
  logic [19:0] coast_q;
  logic [16:0] conf_q, tent_q, unc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= 16'd154;
      cold_q  <= 16'd308;
      hold_q  <= 16'd308;
      coast_q <= 20'd10000;
      conf_q  <= 17'd1311;
      tent_q  <= 17'd65536;
      unc_q   <= 17'd49152;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CODE:   code_q  <= cfg_data_i[15:0];
        REG_COLD:   cold_q  <= cfg_data_i[15:0];
        REG_HOLD:   hold_q  <= cfg_data_i[15:0];
        REG_COAST:  coast_q <= cfg_data_i;
        REG_CONF:   conf_q  <= cfg_data_i[16:0];
        REG_TENT:   tent_q  <= cfg_data_i[16:0];
        REG_UNCERT: unc_q   <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // lock state
  mode_e       mode_q;
  logic [29:0] tim_q, tsl_q, cred_q;
  logic [15:0] qual_q;
  logic        ever_q;
  in_item_t    it_q;

  function automatic logic [29:0] sat_add(input logic [29:0] a, input logic [15:0] b,
                                          input logic [29:0] cap);
    logic [30:0] s;
    s = {1'b0, a} + {15'd0, b};
    return (s > {1'b0, cap}) ? cap : s[29:0];
  endfunction

  // restoring divider for the ramp and hold decay ratios
  logic [33:0] dnum_q, dquo_q;
  logic [33:0] drem_q;
  logic [16:0] dden_q;
  logic [5:0]  dcnt_q;
  logic [34:0] dtrial;

  assign dtrial = {drem_q, dnum_q[33]} - {18'd0, dden_q};
  assign sts_o.div_done = (dcnt_q == 6'(DivSteps));

  // next-state comb for update
  logic [15:0] sq;
  mode_e       m;
  logic [29:0] t, l, c;
  logic [15:0] qn;
  logic        e, need;
  logic [33:0] nnum;
  logic [16:0] nden;
  logic [29:0] warm_cmp;

  always_comb begin
    sq = (it_q.quality > QNine) ? QNine : it_q.quality;
    m = mode_q; t = tim_q; l = tsl_q; c = cred_q; qn = qual_q; e = ever_q;
    need = 1'b0; nnum = '0; nden = '0;
    warm_cmp = {10'd0, coast_q};
    if (!it_q.present) begin
      if (m == MODE_TRACK) begin
        m = MODE_HOLD; t = '0; l = '0;
      end else if (m == MODE_ACQUIRE) begin
        m = MODE_SEARCH; t = '0;
      end
      c = '0;
      t = sat_add(t, it_q.elapsed, TimerMax);
      l = sat_add(l, it_q.elapsed, NeverLocked);
      if (m == MODE_HOLD && t >= {14'd0, hold_q}) begin
        m = MODE_SEARCH; t = '0;
      end
      if (m == MODE_HOLD) begin
        need = 1'b1;
        nnum = {18'd0, qual_q} * {18'd0, hold_q - t[15:0]};
        nden = {1'b0, hold_q};
      end else if (m == MODE_SEARCH) begin
        qn = '0;
      end
    end else begin
      if (m == MODE_SEARCH) begin
        m = MODE_ACQUIRE; t = '0; c = '0;
      end
      if (m == MODE_TRACK) begin
        t = sat_add(t, it_q.elapsed, TimerMax);
        l = '0; qn = sq;
      end else begin
        c = sat_add(c, it_q.elapsed, TimerMax);
        t = sat_add(t, it_q.elapsed, TimerMax);
        if (c >= {14'd0, ((ever_q && tsl_q <= warm_cmp) ? code_q : cold_q)}) begin
          m = MODE_TRACK; t = '0; l = '0; c = '0; e = 1'b1; qn = sq;
        end else begin
          // credit is below a 16-bit requirement here
          need = 1'b1;
          nnum = {18'd0, sq} * {18'd0, c[15:0]};
          nden = {1'b0, ((ever_q && tsl_q <= warm_cmp) ? code_q : cold_q)};
        end
      end
    end
  end

  assign sts_o.need_div = need;

  logic [33:0] cep_num;
  logic [33:0] cep_rnd;
  logic [43:0] cep_prod;
  logic [33:0] cep_q;
  logic [16:0] cep_f;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cep_mul) begin
      cep_num <= {17'd0, tent_q} * {18'd0, QNine - qual_q}
               + {17'd0, conf_q} * {18'd0, qual_q};
    end
  end

  // rounded divide by 36864: drop 12 bits, then multiply by 1/9
  assign cep_rnd  = cep_num + 34'(QNine / 2);
  assign cep_prod = {22'd0, cep_rnd[33:12]} * {22'd0, CepRecip};

  always_comb begin
    cep_q = {15'd0, cep_prod[43:25]};
    if (it_q.uncertain && cep_q < {17'd0, unc_q}) cep_q = {17'd0, unc_q};
    if (cep_q > {17'd0, CepOne}) cep_q = {17'd0, CepOne};
    cep_f = cep_q[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_SEARCH;
      tim_q  <= '0;
      tsl_q  <= NeverLocked;
      cred_q <= '0;
      qual_q <= '0;
      ever_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.update) begin
        mode_q <= m; tim_q <= t; tsl_q <= l; cred_q <= c; qual_q <= qn; ever_q <= e;
        dcnt_q <= '0;
      end else if (cmd_i.div_step && !sts_o.div_done) begin
        dcnt_q <= dcnt_q + 6'd1;
      end
      if (cmd_i.div_step && sts_o.div_done) begin
        qual_q <= dquo_q[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_i;
    if (cmd_i.update) begin
      dnum_q <= nnum; dden_q <= nden; drem_q <= '0; dquo_q <= '0;
    end else if (cmd_i.div_step && !sts_o.div_done) begin
      if (!dtrial[34]) begin
        drem_q <= dtrial[33:0];
        dquo_q <= {dquo_q[32:0], 1'b1};
      end else begin
        drem_q <= {drem_q[32:0], dnum_q[33]};
        dquo_q <= {dquo_q[32:0], 1'b0};
      end
      dnum_q <= {dnum_q[32:0], 1'b0};
    end
    if (cmd_i.finish) begin
      out_o.lock_state    <= mode_q;
      out_o.quality_out   <= qual_q;
      out_o.cep_out       <= it_q.present ? cep_f : 17'd0;
      out_o.bearing_valid <= it_q.present;
    end
  end
endmodule

[rtl/beacon_acquisition_lock_fsm_core.sv]
// Beacon acquisition lock machine.
// Input channel in (bal_in_if sink): one tick item per transfer carrying
// signal presence, quality Q4.12, elapsed ms and the identity-uncertain flag.
// Output channel out (bal_out_if source): one result item per tick with lock
// state, quality, CEP Q1.16 and bearing-valid.
// Configuration: cfg_we_i/cfg_idx_i/cfg_data_i, write only, one register a
// clock, index as listed (code word credit, cold credit, hold limit, coast
// window, confident/tentative/uncertain CEP). Write only while idle.
// Sequence: an accepted item is captured, the state update runs, a ramp or
// hold decay then runs the 34-step restoring divider, the CEP product is
// registered and the result is written to the output register. The CEP
// rounding divide by 36864 is a 12-bit shift and a reciprocal multiply.
// One item at a time; ready is high only with no item in flight.
// A result waits in the output register while the receiver stalls; the next
// item is accepted after it has been taken.
// Reset: registers take their defaults, machine searching, never locked.
module beacon_acquisition_lock_fsm_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bal_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bal_pkg::CfgDatW-1:0] cfg_data_i,
  bal_in_if.sink                      in_if,
  bal_out_if.source                   out_if
);
  import bal_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bal_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bal_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i  (in_if.data),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (out_if.data)
  );
endmodule

[rtl/bal_checker.sv]
module bal_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [16:0] cep,
  input logic bvalid
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(cep)) else $error("stall");
  a_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !bvalid |-> cep == 17'd0) else $error("sentinel");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> cep <= 17'd65536) else $error("cep cap");
endmodule

bind beacon_acquisition_lock_fsm_core bal_checker u_chk (
  .clk_i, .rst_ni,
  .in_valid(in_if.valid), .in_ready(in_if.ready),
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .cep(out_if.data.cep_out), .bvalid(out_if.data.bearing_valid)
);

[tb/sv/beacon_acquisition_lock_fsm_core_tb.sv]
module beacon_acquisition_lock_fsm_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bal_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDatW-1:0]  cfg_data_i = '0;

  bal_in_if  tick_ch ();
  bal_out_if res_ch ();

  beacon_acquisition_lock_fsm_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (tick_ch.sink),
    .out_if     (res_ch.source)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predicted configuration, mirrors the block's registers.
  logic [15:0] code_cr, cold_cr, hold_lim;
  logic [19:0] coast_win;
  logic [16:0] conf_cep, tent_cep, unc_cep;

  // Predicted lock-machine state.
  mode_e       mode_q;
  logic [29:0] in_mode_ms, since_loss_ms, credit_acc;
  logic [15:0] qual_q;
  logic        locked_once;

  out_item_t   expected_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned idle_pct = 21;       // shared idle chance for both sides
  bit          sink_hold = 1'b0;    // long receiver hold-off request
  bit          saw_mode[4];

  function automatic logic [29:0] add_sat(logic [29:0] a, logic [15:0] b, logic [29:0] cap);
    logic [31:0] s;
    s = {2'b0, a} + {16'b0, b};
    return (s > {2'b0, cap}) ? cap : s[29:0];
  endfunction

  function automatic logic [16:0] cep_from_quality(logic [15:0] q, logic unc);
    logic [63:0] num, cep;
    num = 64'(tent_cep) * 64'(QNine - q) + 64'(conf_cep) * 64'(q);
    cep = (num + 64'(QNine / 2)) / 64'(QNine);
    if (unc && cep < 64'(unc_cep)) cep = 64'(unc_cep);
    if (cep > 64'(CepOne)) cep = 64'(CepOne);
    return cep[16:0];
  endfunction

  // Advances the predicted lock machine by one tick.
  function automatic out_item_t lock_tick(in_item_t t);
    out_item_t   r;
    logic [15:0] sq;
    logic [29:0] req;
    logic        warm;
    sq = (t.quality > QNine) ? QNine : t.quality;
    if (!t.present) begin
      if (mode_q == MODE_TRACK) begin
        mode_q = MODE_HOLD; in_mode_ms = '0; since_loss_ms = '0;
      end else if (mode_q == MODE_ACQUIRE) begin
        mode_q = MODE_SEARCH; in_mode_ms = '0;
      end
      credit_acc = '0;
      in_mode_ms = add_sat(in_mode_ms, t.elapsed, TimerMax);
      since_loss_ms = add_sat(since_loss_ms, t.elapsed, NeverLocked);
      if (mode_q == MODE_HOLD && in_mode_ms >= 30'(hold_lim)) begin
        mode_q = MODE_SEARCH; in_mode_ms = '0;
      end
      if (mode_q == MODE_HOLD)
        qual_q = 16'((64'(qual_q) * 64'(30'(hold_lim) - in_mode_ms)) / 64'(hold_lim));
      else if (mode_q == MODE_SEARCH)
        qual_q = '0;
    end else begin
      if (mode_q == MODE_SEARCH) begin
        mode_q = MODE_ACQUIRE; in_mode_ms = '0; credit_acc = '0;
      end
      if (mode_q == MODE_TRACK) begin
        in_mode_ms = add_sat(in_mode_ms, t.elapsed, TimerMax);
        since_loss_ms = '0;
        qual_q = sq;
      end else begin
        credit_acc = add_sat(credit_acc, t.elapsed, TimerMax);
        in_mode_ms = add_sat(in_mode_ms, t.elapsed, TimerMax);
        warm = locked_once && (since_loss_ms <= 30'(coast_win));
        req = warm ? 30'(code_cr) : 30'(cold_cr);
        if (credit_acc >= req) begin
          mode_q = MODE_TRACK; in_mode_ms = '0; since_loss_ms = '0;
          credit_acc = '0; locked_once = 1'b1; qual_q = sq;
        end else begin
          qual_q = 16'((64'(sq) * 64'(credit_acc)) / 64'(req));
        end
      end
    end
    saw_mode[mode_q] = 1'b1;
    r.lock_state    = mode_q;
    r.quality_out   = qual_q;
    r.cep_out       = t.present ? cep_from_quality(qual_q, t.uncertain) : '0;
    r.bearing_valid = t.present;
    return r;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_CODE:   code_cr   = val[15:0];
      REG_COLD:   cold_cr   = val[15:0];
      REG_HOLD:   hold_lim  = val[15:0];
      REG_COAST:  coast_win = val[19:0];
      REG_CONF:   conf_cep  = val[16:0];
      REG_TENT:   tent_cep  = val[16:0];
      REG_UNCERT: unc_cep   = val[16:0];
      default: ;
    endcase
  endtask

  // Waits for every predicted result, then for the block to settle.
  task automatic drain();
    wait (expected_results.size() == 0);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_all(logic [15:0] cw, logic [15:0] cd, logic [15:0] hl,
                           logic [19:0] cwin, logic [16:0] cf, logic [16:0] tn,
                           logic [16:0] un);
    drain();
    write_reg(REG_CODE, cw);  write_reg(REG_COLD, cd);
    write_reg(REG_HOLD, hl);  write_reg(REG_COAST, cwin);
    write_reg(REG_CONF, cf);  write_reg(REG_TENT, tn);
    write_reg(REG_UNCERT, un);
  endtask

  // Sends one tick item; valid stays up until the handshake.
  task automatic send_tick(logic pres, logic [15:0] q, logic [15:0] dt, logic unc);
    in_item_t t;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    t.present = pres; t.quality = q; t.elapsed = dt; t.uncertain = unc;
    tick_ch.data  = t;
    tick_ch.valid = 1'b1;
    do @(posedge clk_i); while (!tick_ch.ready);
    expected_results.push_back(lock_tick(t));
    items_sent++;
    @(negedge clk_i);
    tick_ch.valid = 1'b0;
  endtask

  task automatic rand_tick(int unsigned present_pct, logic [15:0] dt_max);
    logic [15:0] q;
    q = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(36864));
    send_tick($urandom_range(99) < present_pct, q, 16'($urandom_range(dt_max)),
              $urandom_range(3) == 0);
  endtask

  task automatic test_directed();
    send_tick(1'b0, 16'd0, 16'd0, 1'b0);
    send_tick(1'b1, 16'hFFFF, 16'd0, 1'b1);        // quality above nine
    send_tick(1'b1, 16'd36864, 16'd100, 1'b0);
    send_tick(1'b1, 16'd20000, 16'd300, 1'b1);     // cold lock
    send_tick(1'b1, 16'd12345, 16'hFFFF, 1'b0);
    send_tick(1'b0, 16'd0, 16'd50, 1'b0);          // into hold
    send_tick(1'b0, 16'd0, 16'd100, 1'b1);         // decay
    send_tick(1'b1, 16'd30000, 16'd160, 1'b0);     // warm relock
    send_tick(1'b0, 16'd0, 16'hFFFF, 1'b0);        // hold timeout
    send_tick(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
    send_tick(1'b1, 16'd0, 16'd1, 1'b0);
    send_tick(1'b0, 16'd0, 16'd1, 1'b0);           // acquire lost
  endtask

  task automatic test_zero_limits();
    // Zero credit locks at once; zero hold limit drops hold on first blind tick.
    write_all(16'd0, 16'd0, 16'd0, 20'd0, 17'd0, 17'd0, 17'd0);
    send_tick(1'b1, 16'd1000, 16'd0, 1'b0);
    send_tick(1'b0, 16'd0, 16'd0, 1'b1);
    send_tick(1'b1, 16'd36864, 16'd0, 1'b1);
    send_tick(1'b1, 16'd36864, 16'd7, 1'b0);
  endtask

  task automatic test_max_limits();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
    repeat (8) send_tick(1'b1, 16'($urandom), 16'hFFFF, 1'($urandom));
    repeat (4) send_tick(1'b0, 16'd0, 16'd9000, 1'b1);
  endtask

  task automatic test_random_sessions(int unsigned n, logic [15:0] dt_max);
    int unsigned k;
    k = 0;
    while (k < n) begin
      // Mostly lock / hold / relock runs, with blind and noisy stretches.
      case ($urandom_range(3))
        0: repeat ($urandom_range(1, 15)) begin rand_tick(100, dt_max); k++; end
        1: repeat ($urandom_range(1, 6))  begin rand_tick(0, dt_max);   k++; end
        default: repeat ($urandom_range(1, 10)) begin rand_tick(70, dt_max); k++; end
      endcase
    end
  endtask

  task automatic test_back_pressure();
    // Receiver holds off while the sender keeps offering.
    sink_hold = 1'b1;
    fork
      repeat (6) rand_tick(80, 16'd200);
      begin repeat (400) @(negedge clk_i); sink_hold = 1'b0; end
    join
    drain();   // sender pause until every result is in
  endtask

  // Receiver side: ready toggles at the falling edge.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_ch.ready = !sink_hold && ($urandom_range(99) >= idle_pct);
    end
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", res_ch.data);
      end else begin
        exp_r = expected_results.pop_front();
        if (res_ch.data.lock_state !== exp_r.lock_state ||
            res_ch.data.quality_out !== exp_r.quality_out ||
            res_ch.data.cep_out !== exp_r.cep_out ||
            res_ch.data.bearing_valid !== exp_r.bearing_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch item %0d: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     results_seen, exp_r.lock_state, exp_r.quality_out, exp_r.cep_out,
                     exp_r.bearing_valid, res_ch.data.lock_state, res_ch.data.quality_out,
                     res_ch.data.cep_out, res_ch.data.bearing_valid);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > 1500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    tick_ch.valid = 1'b0;
    tick_ch.data  = '0;
    code_cr = 16'd154; cold_cr = 16'd308; hold_lim = 16'd308;
    coast_win = 20'd10000; conf_cep = 17'd1311; tent_cep = 17'd65536;
    unc_cep = 17'd49152;
    mode_q = MODE_SEARCH; in_mode_ms = '0; since_loss_ms = NeverLocked;
    credit_acc = '0; qual_q = '0; locked_once = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_sessions(250, 16'd120);
    test_back_pressure();
    idle_pct = 0;                      // stretch with no idling
    test_random_sessions(150, 16'd120);
    idle_pct = 21;
    test_zero_limits();
    test_max_limits();
    write_all(16'($urandom_range(400)), 16'($urandom_range(800)), 16'($urandom_range(1, 600)),
              20'($urandom_range(2000)), 17'($urandom_range(65536)),
              17'($urandom_range(65536)), 17'($urandom_range(65536)));
    test_random_sessions(300, 16'd150);
    write_all(16'd154, 16'd308, 16'd308, 20'd10000, 17'd1311, 17'd65536, 17'd49152);
    test_random_sessions(300, 16'hFFFF >> $urandom_range(15));
    drain();

    $display("sent %0d tick items, checked %0d results, modes seen %0b%0b%0b%0b",
             items_sent, results_seen, saw_mode[3], saw_mode[2], saw_mode[1], saw_mode[0]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
